>>> hw/rtl/pretrigger_capture_fifo_top_assert.svh
// assertion macros for the pretrigger capture fifo top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PRETRIGGER_CAPTURE_FIFO_TOP_ASSERT_SVH
`define PRETRIGGER_CAPTURE_FIFO_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pcf_pkg.sv
// shared types and constants for the pretrigger capture fifo
// no dependencies
package pcf_pkg;

  localparam int unsigned SLOTS_DEFAULT = 256;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TRIG = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOT_TRIG = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] payload;
    logic [7:0]  length;
    logic        stamp;
  } rec_t;

endpackage

>>> hw/rtl/pretrigger_capture_fifo_top.sv
// pretrigger capture fifo: the result is registered in the cycle after the input transfer;
// one item per cycle sustained unless the output stalls; the record ring is a single memory
// with one write port and one registered read port that is kept pointed at the oldest record
// reset (rst_ni low, asynchronous) clears pointers, fill count, trigger flag and the
// result valid; the record memory is not cleared and needs no clearing pass
// depends on pcf_pkg and pretrigger_capture_fifo_top_assert.svh
module pretrigger_capture_fifo_top #(
  parameter int unsigned SLOTS = pcf_pkg::SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] payload_i,
  input  logic [7:0]  length_i,
  input  logic        trigger_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] out_payload_o,
  output logic [7:0]  out_length_o,
  output logic        out_stamp_o,
  output logic        dropped_o,
  output logic [7:0]  fill_count_o
);
  import pcf_pkg::*;

  localparam int unsigned PW = $clog2(SLOTS);
  localparam int unsigned RW = $bits(rec_t);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);
  localparam logic [PW-1:0] FULL = PW'(SLOTS - 1);
  localparam logic [PW-1:0] HALF = PW'((SLOTS - 1) / 2);

  logic [RW-1:0] mem_q [SLOTS];
  rec_t          rdata_q;

  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d, cnt_q, cnt_d;
  logic          trig_q, trig_d;

  logic          out_valid_q;
  logic [1:0]    status_q, status_d;
  logic [63:0]   out_payload_q, out_payload_d;
  logic [7:0]    out_length_q, out_length_d;
  logic          out_stamp_q, out_stamp_d;
  logic          dropped_q, dropped_d;

  logic          accept;
  logic          wr_en;
  rec_t          wdata;
  logic [PW-1:0] cnt_mid, rd_mid;
  logic [PW+7:0] cnt_ext;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign wdata.payload = payload_i;
  assign wdata.length  = length_i;
  assign wdata.stamp   = trig_q;

  always_comb begin
    wr_d          = wr_q;
    rd_d          = rd_q;
    cnt_d         = cnt_q;
    trig_d        = trig_q;
    wr_en         = 1'b0;
    status_d      = STAT_OK;
    out_payload_d = '0;
    out_length_d  = '0;
    out_stamp_d   = 1'b0;
    dropped_d     = 1'b0;
    cnt_mid       = cnt_q;
    rd_mid        = rd_q;
    if (accept) begin
      unique case (op_e'(operation_i))
        OP_PUSH: begin
          // before the trigger keep only the recent half, oldest goes first
          if (!trig_q && cnt_q >= HALF) begin
            dropped_d = 1'b1;
            cnt_mid   = cnt_q - 1'b1;
            rd_mid    = advance(rd_q);
          end
          rd_d = rd_mid;
          if (cnt_mid < FULL) begin
            wr_en = 1'b1;
            wr_d  = advance(wr_q);
            cnt_d = cnt_mid + 1'b1;
          end else begin
            cnt_d    = cnt_mid;
            status_d = STAT_FULL;
          end
        end
        OP_POP: begin
          if (!trig_q) begin
            status_d = STAT_NOT_TRIG;
          end else if (cnt_q == '0) begin
            status_d = STAT_EMPTY;
          end else begin
            out_payload_d = rdata_q.payload;
            out_length_d  = rdata_q.length;
            out_stamp_d   = rdata_q.stamp;
            rd_d          = advance(rd_q);
            cnt_d         = cnt_q - 1'b1;
          end
        end
        OP_TRIG: trig_d = trigger_value_i;
        default: ;
      endcase
    end
  end

  // read port always follows the next oldest slot, a write to that slot bypasses
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wdata;
    end
    if (wr_en && wr_q == rd_d) begin
      rdata_q <= wdata;
    end else begin
      rdata_q <= mem_q[rd_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
      trig_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      trig_q <= trig_d;
      if (!in_stall_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      out_payload_q <= out_payload_d;
      out_length_q  <= out_length_d;
      out_stamp_q   <= out_stamp_d;
      dropped_q     <= dropped_d;
    end
  end

  assign cnt_ext = {8'b0, cnt_q};

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_payload_o = out_payload_q;
  assign out_length_o  = out_length_q;
  assign out_stamp_o   = out_stamp_q;
  assign dropped_o     = dropped_q;
  assign fill_count_o  = cnt_ext[7:0];

`include "pretrigger_capture_fifo_top_assert.svh"

  `PCF_ASSERT_NOW(a_cnt_matches_ptrs, 1'b1,
    ((wr_q >= rd_q) ? (32'(wr_q) - 32'(rd_q)) : (32'(wr_q) + SLOTS - 32'(rd_q))) == 32'(cnt_q),
    "fill count out of step with pointers")
  `PCF_ASSERT_NEXT(a_no_full_before_trig,
    accept && !trig_q && operation_i == OP_PUSH, status_q == STAT_OK,
    "push refused before trigger")
  `PCF_ASSERT_NOW(a_drop_only_ok, out_valid_q && dropped_q, status_q == STAT_OK && !trig_q,
    "drop with bad status or after trigger")

endmodule
